/* src/hse_pkg.sv */
// Shared constants, codes and helpers of the hypercube slice enumerator.
package hse_pkg;

    localparam int NUM_DIMS   = 3;
    localparam int SHARE_BITS = 6;
    localparam int REG_BITS   = 7;
    localparam int ID_BITS    = 18;
    localparam int FUNC_BITS  = 2;

    localparam int PROD_BITS    = NUM_DIMS * SHARE_BITS + 1;
    localparam int DIM_BITS     = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
    localparam int CNT_BITS     = $clog2(ID_BITS);
    localparam int CFG_ADDR_BITS = $clog2(2 * NUM_DIMS);

    localparam int S_TDATA_BITS = ((ID_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((ID_BITS + 1 + 7) / 8) * 8;

    localparam int REG_SIZE_BASE  = 0;
    localparam int REG_COORD_BASE = NUM_DIMS;

    localparam logic [REG_BITS-1:0] SIZE_RESET  = REG_BITS'(1);
    localparam logic [REG_BITS-1:0] COORD_RESET = '1;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_RESTART = 2'd0,
        FUNC_EMIT    = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    // size 0 counts as 1, sizes above 2^SHARE_BITS are capped
    function automatic logic [REG_BITS-1:0] eff_size(input logic [REG_BITS-1:0] s);
        logic [REG_BITS-1:0] r;
        r = s;
        if (s == '0) r = REG_BITS'(1);
        else if (s > REG_BITS'(1 << SHARE_BITS)) r = REG_BITS'(1 << SHARE_BITS);
        return r;
    endfunction

endpackage

/* src/hypercube_slice_enumerator.sv */
// Top level: slice enumeration and membership test with serial multiply and divide.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   tuser: func; tdata: query_id
//  m_        out  m_tvalid/m_tready   tdata: serial_id, member; tlast: is_last;
//                                     tuser: exhausted
//  cfg_      in   cfg_we              cfg_addr, cfg_wdata
//
// Restart, exhausted emit, unused codes: done state, then the output register.
// Emit: two shift-add multiplies of seven steps each (Horner).
// Query: two such multiplies for the cube product, then an 18-step restoring division
// per dimension; an id outside the cube ends after the product.
// One item at a time; a new item is taken while the previous result waits.
// Reset is synchronous and needs no clearing pass.
module hypercube_slice_enumerator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hse_pkg::S_TDATA_BITS-1:0]    s_tdata,   // query_id, zero pad
    input  logic [hse_pkg::FUNC_BITS-1:0]       s_tuser,   // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hse_pkg::M_TDATA_BITS-1:0]    m_tdata,   // serial_id, member, zero pad
    output logic                                m_tlast,   // is_last
    output logic                                m_tuser,   // exhausted
    input  logic                                cfg_we,
    input  logic [hse_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [hse_pkg::REG_BITS-1:0]        cfg_wdata
);

    localparam int N  = hse_pkg::NUM_DIMS;
    localparam int RB = hse_pkg::REG_BITS;
    localparam int SB = hse_pkg::SHARE_BITS;
    localparam int IB = hse_pkg::ID_BITS;
    localparam int PB = hse_pkg::PROD_BITS;
    localparam int DB = hse_pkg::DIM_BITS;
    localparam int CB = hse_pkg::CNT_BITS;
    localparam int AB = hse_pkg::CFG_ADDR_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

    state_t               state_reg, state_next;
    hse_pkg::func_t       op_reg, op_next;
    logic [DB-1:0]        dim_reg, dim_next;
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic [PB-1:0]        a_reg, a_next;
    logic [PB-1:0]        p_reg, p_next;
    logic [RB-1:0]        mr_reg, mr_next;
    logic [IB-1:0]        q_reg, q_next;
    logic [RB-1:0]        r_reg, r_next;
    logic                 match_reg, match_next;

    logic [IB-1:0]        res_id_reg, res_id_next;
    logic                 res_last_reg, res_last_next;
    logic                 res_exh_reg, res_exh_next;
    logic                 res_mem_reg, res_mem_next;

    logic                 m_valid_reg, m_valid_next;
    logic [IB-1:0]        m_id_reg, m_id_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_exh_reg, m_exh_next;
    logic                 m_mem_reg, m_mem_next;

    logic [RB-1:0]        size_reg [N], size_next [N];
    logic [RB-1:0]        coord_reg [N], coord_next [N];
    logic [SB-1:0]        pos_reg [N], pos_next [N];
    logic                 finished_reg, finished_next;

    logic [RB-1:0]        eff_s [N];
    logic                 wild [N];
    logic [SB-1:0]        adv_pos [N];
    logic                 adv_wrap;
    logic [PB-1:0]        mul_sum;
    logic [RB:0]          div_t, div_s;
    logic                 div_ge;
    logic [RB-1:0]        div_rem;
    logic [DB-1:0]        dim_dn, dim_up;
    logic                 ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(hse_pkg::M_TDATA_BITS - IB - 1){1'b0}}, m_mem_reg, m_id_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_exh_reg;

    always_comb begin
        for (int d = 0; d < N; d++) begin
            eff_s[d] = hse_pkg::eff_size(size_reg[d]);
            wild[d]  = coord_reg[d][RB-1];
        end
        adv_wrap = 1'b1;
        for (int d = 0; d < N; d++) begin
            adv_pos[d] = pos_reg[d];
            if (adv_wrap && wild[d]) begin
                if ({1'b0, pos_reg[d]} + (SB + 1)'(1) >= (SB + 1)'(eff_s[d])) begin
                    adv_pos[d] = '0;
                end else begin
                    adv_pos[d] = pos_reg[d] + SB'(1);
                    adv_wrap   = 1'b0;
                end
            end
        end
        mul_sum = p_reg + (mr_reg[0] ? a_reg : '0);
        div_t   = {r_reg, q_reg[IB-1]};
        div_s   = {1'b0, eff_s[dim_reg]};
        div_ge  = (div_t >= div_s);
        div_rem = div_ge ? RB'(div_t - div_s) : RB'(div_t);
        dim_dn  = dim_reg - DB'(1);
        dim_up  = dim_reg + DB'(1);
        ok      = match_reg && (wild[dim_reg] || div_rem == coord_reg[dim_reg]);
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        dim_next      = dim_reg;
        cnt_next      = cnt_reg;
        a_next        = a_reg;
        p_next        = p_reg;
        mr_next       = mr_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        match_next    = match_reg;
        res_id_next   = res_id_reg;
        res_last_next = res_last_reg;
        res_exh_next  = res_exh_reg;
        res_mem_next  = res_mem_reg;
        m_valid_next  = m_valid_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        m_exh_next    = m_exh_reg;
        m_mem_next    = m_mem_reg;
        finished_next = finished_reg;
        for (int d = 0; d < N; d++) begin
            size_next[d]  = size_reg[d];
            coord_next[d] = coord_reg[d];
            pos_next[d]   = pos_reg[d];
        end

        if (cfg_we) begin
            for (int d = 0; d < N; d++) begin
                if (cfg_addr == AB'(hse_pkg::REG_SIZE_BASE + d)) size_next[d] = cfg_wdata;
                if (cfg_addr == AB'(hse_pkg::REG_COORD_BASE + d)) coord_next[d] = cfg_wdata;
            end
        end

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = hse_pkg::func_t'(s_tuser);
                    q_next        = s_tdata[IB-1:0];
                    res_id_next   = '0;
                    res_last_next = 1'b0;
                    res_exh_next  = 1'b0;
                    res_mem_next  = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_DONE;
                    unique case (hse_pkg::func_t'(s_tuser))
                        hse_pkg::FUNC_RESTART: begin
                            finished_next = 1'b0;
                            for (int d = 0; d < N; d++) begin
                                if (wild[d]) begin
                                    pos_next[d] = '0;
                                end else begin
                                    pos_next[d] = coord_reg[d][SB-1:0];
                                    if (coord_reg[d] >= eff_s[d]) finished_next = 1'b1;
                                end
                            end
                        end
                        hse_pkg::FUNC_EMIT: begin
                            if (finished_reg) begin
                                res_exh_next = 1'b1;
                            end else begin
                                // Horner from the top dimension down
                                a_next     = PB'(pos_reg[N-1]);
                                mr_next    = eff_s[N-2];
                                p_next     = PB'(pos_reg[N-2]);
                                dim_next   = DB'(N - 2);
                                state_next = ST_MUL;
                            end
                        end
                        hse_pkg::FUNC_QUERY: begin
                            a_next     = PB'(eff_s[0]);
                            mr_next    = eff_s[1];
                            p_next     = '0;
                            dim_next   = DB'(1);
                            state_next = ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                p_next   = mul_sum;
                a_next   = {a_reg[PB-2:0], 1'b0};
                mr_next  = {1'b0, mr_reg[RB-1:1]};
                cnt_next = cnt_reg + CB'(1);
                if (cnt_reg == CB'(RB - 1)) begin
                    cnt_next = '0;
                    if (op_reg == hse_pkg::FUNC_EMIT) begin
                        if (dim_reg == '0) begin
                            res_id_next   = mul_sum[IB-1:0];
                            res_last_next = adv_wrap;
                            finished_next = adv_wrap;
                            for (int d = 0; d < N; d++) pos_next[d] = adv_pos[d];
                            state_next    = ST_DONE;
                        end else begin
                            a_next   = mul_sum;
                            mr_next  = eff_s[dim_dn];
                            p_next   = PB'(pos_reg[dim_dn]);
                            dim_next = dim_dn;
                        end
                    end else begin
                        if (dim_reg == DB'(N - 1)) begin
                            if (PB'(q_reg) >= mul_sum) begin
                                state_next = ST_DONE;
                            end else begin
                                dim_next   = '0;
                                r_next     = '0;
                                match_next = 1'b1;
                                state_next = ST_DIV;
                            end
                        end else begin
                            a_next   = mul_sum;
                            mr_next  = eff_s[dim_up];
                            p_next   = '0;
                            dim_next = dim_up;
                        end
                    end
                end
            end
            ST_DIV: begin
                r_next   = div_rem;
                q_next   = {q_reg[IB-2:0], div_ge};
                cnt_next = cnt_reg + CB'(1);
                if (cnt_reg == CB'(IB - 1)) begin
                    cnt_next   = '0;
                    match_next = ok;
                    r_next     = '0;
                    if (dim_reg == DB'(N - 1)) begin
                        res_mem_next = ok;
                        state_next   = ST_DONE;
                    end else begin
                        dim_next = dim_up;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_id_next    = res_id_reg;
                    m_last_next  = res_last_reg;
                    m_exh_next   = res_exh_reg;
                    m_mem_next   = res_mem_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            finished_reg <= 1'b0;
            for (int d = 0; d < N; d++) begin
                size_reg[d]  <= hse_pkg::SIZE_RESET;
                coord_reg[d] <= hse_pkg::COORD_RESET;
                pos_reg[d]   <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            finished_reg <= finished_next;
            for (int d = 0; d < N; d++) begin
                size_reg[d]  <= size_next[d];
                coord_reg[d] <= coord_next[d];
                pos_reg[d]   <= pos_next[d];
            end
            op_reg       <= op_next;
            dim_reg      <= dim_next;
            cnt_reg      <= cnt_next;
            a_reg        <= a_next;
            p_reg        <= p_next;
            mr_reg       <= mr_next;
            q_reg        <= q_next;
            r_reg        <= r_next;
            match_reg    <= match_next;
            res_id_reg   <= res_id_next;
            res_last_reg <= res_last_next;
            res_exh_reg  <= res_exh_next;
            res_mem_reg  <= res_mem_next;
            m_id_reg     <= m_id_next;
            m_last_reg   <= m_last_next;
            m_exh_reg    <= m_exh_next;
            m_mem_reg    <= m_mem_next;
        end
    end

endmodule

/* src/hse_checker.sv */
// Port-level checks of the hypercube slice enumerator and their binding.
module hse_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [hse_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input logic                                m_tlast,
    input logic                                m_tuser
);

    localparam int IB = hse_pkg::ID_BITS;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // an exhausted emit carries no id and no last flag
    a_exh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[IB-1:0] == '0 && !m_tlast && !m_tdata[IB])
        else $error("exhausted result with payload");

    // a membership hit is never an emit
    a_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[IB] |-> m_tdata[IB-1:0] == '0 && !m_tlast && !m_tuser)
        else $error("member flag mixed with emit fields");

    // one item at a time: the input closes after an accept
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after accept");

endmodule

bind hypercube_slice_enumerator hse_checker u_hse_checker (.*);

/* verif/hse_slice_checker.sv */
// Checker for the hypercube slice enumerator: predicts each result and compares it.
module hse_slice_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [hse_pkg::S_TDATA_BITS-1:0]    s_tdata,   // query_id, zero pad
    input  logic [hse_pkg::FUNC_BITS-1:0]       s_tuser,   // func
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [hse_pkg::M_TDATA_BITS-1:0]    m_tdata,   // serial_id, member, zero pad
    input  logic                                m_tlast,   // is_last
    input  logic                                m_tuser,   // exhausted
    input  logic                                cfg_we,
    input  logic [hse_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [hse_pkg::REG_BITS-1:0]        cfg_wdata,
    output int                                  err_count,
    output int                                  awaited,
    output int                                  n_ids,
    output int                                  n_lasts,
    output int                                  n_exhausted,
    output int                                  n_queries,
    output int                                  n_members
);
    localparam int NUM_DIMS       = hse_pkg::NUM_DIMS;
    localparam int SHARE_BITS     = hse_pkg::SHARE_BITS;
    localparam int REG_BITS       = hse_pkg::REG_BITS;
    localparam int ID_BITS        = hse_pkg::ID_BITS;
    localparam int REG_SIZE_BASE  = hse_pkg::REG_SIZE_BASE;
    localparam int REG_COORD_BASE = hse_pkg::REG_COORD_BASE;

    typedef struct packed {
        logic [ID_BITS-1:0] serial_id;
        logic               is_last;
        logic               exhausted;
        logic               member;
    } slice_result_t;

    logic [SHARE_BITS-1:0] walk_pos [NUM_DIMS];
    logic                  walk_done;
    logic [REG_BITS-1:0]   size_q   [NUM_DIMS];
    logic [REG_BITS-1:0]   coord_q  [NUM_DIMS];
    slice_result_t         awaited_results [$];
    int                    fails;

    function automatic int share_span(input int d);
        int s;
        s = size_q[d];
        if (s == 0) s = 1;
        else if (s > (1 << SHARE_BITS)) s = 1 << SHARE_BITS;
        return s;
    endfunction

    function automatic bit is_wildcard(input int d);
        return coord_q[d][REG_BITS-1];
    endfunction

    // updates the walk state and returns the result of one item
    function automatic slice_result_t next_slice_result(input hse_pkg::func_t f,
                                                        input logic [ID_BITS-1:0] q);
        slice_result_t r;
        int d, id, w, x, c, total;
        bit carry;
        r = '0;
        case (f)
            hse_pkg::FUNC_RESTART: begin
                walk_done = 1'b0;
                for (d = 0; d < NUM_DIMS; d++) begin
                    if (is_wildcard(d)) begin
                        walk_pos[d] = '0;
                    end else begin
                        if (int'(coord_q[d]) >= share_span(d)) walk_done = 1'b1;
                        walk_pos[d] = coord_q[d][SHARE_BITS-1:0];
                    end
                end
            end
            hse_pkg::FUNC_EMIT: begin
                if (walk_done) begin
                    r.exhausted = 1'b1;
                end else begin
                    id = 0;
                    w = 1;
                    for (d = 0; d < NUM_DIMS; d++) begin
                        id += int'(walk_pos[d]) * w;
                        w *= share_span(d);
                    end
                    r.serial_id = id[ID_BITS-1:0];
                    carry = 1'b1;
                    for (d = 0; d < NUM_DIMS && carry; d++) begin
                        if (is_wildcard(d)) begin
                            if (int'(walk_pos[d]) + 1 >= share_span(d)) begin
                                walk_pos[d] = '0;
                            end else begin
                                walk_pos[d] = walk_pos[d] + 1'b1;
                                carry = 1'b0;
                            end
                        end
                    end
                    if (carry) begin
                        walk_done = 1'b1;
                        r.is_last = 1'b1;
                    end
                end
            end
            hse_pkg::FUNC_QUERY: begin
                total = 1;
                for (d = 0; d < NUM_DIMS; d++) total *= share_span(d);
                x = q;
                r.member = (x < total);
                if (r.member) begin
                    for (d = 0; d < NUM_DIMS; d++) begin
                        c = x % share_span(d);
                        x = x / share_span(d);
                        if (!is_wildcard(d) && c != int'(coord_q[d])) r.member = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        slice_result_t want;
        slice_result_t got;
        int d;
        if (!aresetn) begin
            for (d = 0; d < NUM_DIMS; d++) begin
                walk_pos[d] = '0;
                size_q[d]   = hse_pkg::SIZE_RESET;
                coord_q[d]  = hse_pkg::COORD_RESET;
            end
            walk_done = 1'b0;
            awaited_results.delete();
            fails = 0;
            n_ids       <= 0;
            n_lasts     <= 0;
            n_exhausted <= 0;
            n_queries   <= 0;
            n_members   <= 0;
        end else begin
            if (cfg_we) begin
                if (int'(cfg_addr) < REG_COORD_BASE)
                    size_q[int'(cfg_addr) - REG_SIZE_BASE] = cfg_wdata;
                else if (int'(cfg_addr) < REG_COORD_BASE + NUM_DIMS)
                    coord_q[int'(cfg_addr) - REG_COORD_BASE] = cfg_wdata;
            end
            // a result never leaves with its own item's accept, so compare first
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no item outstanding: serial_id %0d",
                           m_tdata[ID_BITS-1:0]);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[ID_BITS-1:0] !== want.serial_id) begin
                        $error("serial_id: expected %0d, actual %0d",
                               want.serial_id, m_tdata[ID_BITS-1:0]);
                        fails++;
                    end
                    if (m_tlast !== want.is_last) begin
                        $error("is_last: expected %0b, actual %0b", want.is_last, m_tlast);
                        fails++;
                    end
                    if (m_tuser !== want.exhausted) begin
                        $error("exhausted: expected %0b, actual %0b",
                               want.exhausted, m_tuser);
                        fails++;
                    end
                    if (m_tdata[ID_BITS] !== want.member) begin
                        $error("member: expected %0b, actual %0b",
                               want.member, m_tdata[ID_BITS]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                got = next_slice_result(hse_pkg::func_t'(s_tuser), s_tdata[ID_BITS-1:0]);
                awaited_results = {awaited_results, got};
                if (hse_pkg::func_t'(s_tuser) == hse_pkg::FUNC_EMIT && !got.exhausted)
                    n_ids <= n_ids + 1;
                if (got.is_last) n_lasts <= n_lasts + 1;
                if (got.exhausted) n_exhausted <= n_exhausted + 1;
                if (hse_pkg::func_t'(s_tuser) == hse_pkg::FUNC_QUERY)
                    n_queries <= n_queries + 1;
                if (got.member) n_members <= n_members + 1;
            end
        end
        err_count <= fails;
        awaited   <= awaited_results.size();
    end

endmodule

/* verif/tb_hypercube_slice_enumerator.sv */
// Testbench top for the hypercube slice enumerator: stimulus, flow control and verdict.
module tb_hypercube_slice_enumerator;

    localparam int NUM_DIMS       = hse_pkg::NUM_DIMS;
    localparam int SHARE_BITS     = hse_pkg::SHARE_BITS;
    localparam int REG_BITS       = hse_pkg::REG_BITS;
    localparam int ID_BITS        = hse_pkg::ID_BITS;
    localparam int FUNC_BITS      = hse_pkg::FUNC_BITS;
    localparam int S_TDATA_BITS   = hse_pkg::S_TDATA_BITS;
    localparam int M_TDATA_BITS   = hse_pkg::M_TDATA_BITS;
    localparam int CFG_ADDR_BITS  = hse_pkg::CFG_ADDR_BITS;
    localparam int REG_SIZE_BASE  = hse_pkg::REG_SIZE_BASE;
    localparam int REG_COORD_BASE = hse_pkg::REG_COORD_BASE;

    localparam int ID_MAX      = (1 << ID_BITS) - 1;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int QUIET_PHASE = 3;
    localparam int HOLD_PHASE  = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic [FUNC_BITS-1:0]      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      m_tlast;
    logic                      m_tuser;
    logic                      cfg_we;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [REG_BITS-1:0]       cfg_wdata;

    int err_count, awaited;
    int n_ids, n_lasts, n_exhausted, n_queries, n_members;

    logic [REG_BITS-1:0] cur_size  [NUM_DIMS];
    logic [REG_BITS-1:0] cur_coord [NUM_DIMS];
    bit                  quiet;
    int                  phase;
    int                  stall_cycles;

    hypercube_slice_enumerator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    hse_slice_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .err_count   (err_count),
        .awaited     (awaited),
        .n_ids       (n_ids),
        .n_lasts     (n_lasts),
        .n_exhausted (n_exhausted),
        .n_queries   (n_queries),
        .n_members   (n_members)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, one long hold-off, none in the quiet phase
    initial begin : receiver
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase == HOLD_PHASE && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int dim_len(input int d);
        int s;
        s = cur_size[d];
        if (s == 0) s = 1;
        else if (s > (1 << SHARE_BITS)) s = 1 << SHARE_BITS;
        return s;
    endfunction

    function automatic int slice_ids();
        int d, n;
        n = 1;
        for (d = 0; d < NUM_DIMS; d++) begin
            if (cur_coord[d][REG_BITS-1]) n *= dim_len(d);
            else if (int'(cur_coord[d]) >= dim_len(d)) n = 0;
        end
        return n;
    endfunction

    // an id built from a random point of the slice
    function automatic logic [ID_BITS-1:0] slice_point();
        int d, id, w, p;
        id = 0;
        w = 1;
        for (d = 0; d < NUM_DIMS; d++) begin
            if (cur_coord[d][REG_BITS-1]) p = $urandom_range(dim_len(d) - 1);
            else p = cur_coord[d];
            id += p * w;
            w *= dim_len(d);
        end
        return id[ID_BITS-1:0];
    endfunction

    function automatic logic [ID_BITS-1:0] pick_query();
        int r, total, d;
        r = $urandom_range(99);
        total = 1;
        for (d = 0; d < NUM_DIMS; d++) total *= dim_len(d);
        if (r < 50) return slice_point();
        if (r < 75) return ID_BITS'($urandom_range(total - 1));
        return ID_BITS'($urandom_range(ID_MAX));
    endfunction

    task automatic send_item(input hse_pkg::func_t f, input logic [ID_BITS-1:0] q);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= S_TDATA_BITS'(q);
        do @(posedge aclk); while (!s_tready);
        if (!quiet && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // drain, then write every register from cur_size / cur_coord
    task automatic load_regs();
        int i;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited != 0);
        repeat (4) @(posedge aclk);
        for (i = 0; i < 2 * NUM_DIMS; i++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= CFG_ADDR_BITS'(i);
            if (i < REG_COORD_BASE) cfg_wdata <= cur_size[i - REG_SIZE_BASE];
            else cfg_wdata <= cur_coord[i - REG_COORD_BASE];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int s0, input int s1, input int s2,
                             input int c0, input int c1, input int c2);
        cur_size[0]  = REG_BITS'(s0);
        cur_size[1]  = REG_BITS'(s1);
        cur_size[2]  = REG_BITS'(s2);
        cur_coord[0] = REG_BITS'(c0);
        cur_coord[1] = REG_BITS'(c1);
        cur_coord[2] = REG_BITS'(c2);
        load_regs();
    endtask

    task automatic random_config();
        int d, r, c;
        for (d = 0; d < NUM_DIMS; d++) begin
            r = $urandom_range(99);
            if (r < 6) cur_size[d] = '0;
            else if (r < 14) cur_size[d] = REG_BITS'(1 << SHARE_BITS);
            else if (r < 20) cur_size[d] = REG_BITS'($urandom_range(65, 127));
            else cur_size[d] = REG_BITS'($urandom_range(1, 6));
        end
        for (d = 0; d < NUM_DIMS; d++) begin
            r = $urandom_range(99);
            if (r < 45) c = -1;
            else if (r < 55) c = -int'($urandom_range(2, 64));
            else if (r < 65) c = $urandom_range(63);
            else c = $urandom_range(dim_len(d) - 1);
            cur_coord[d] = REG_BITS'(c);
        end
        load_regs();
    endtask

    // restart-and-walk sequences with queries, unused codes and early restarts mixed in
    task automatic random_phase(input int n);
        int k, i, run, r;
        k = 0;
        while (k < n) begin
            send_item(hse_pkg::FUNC_RESTART, ID_BITS'($urandom_range(ID_MAX)));
            k++;
            run = slice_ids();
            run = (run > 40) ? $urandom_range(1, 40) : run + $urandom_range(2);
            for (i = 0; i < run && k < n; i++) begin
                r = $urandom_range(99);
                if (r < 25) begin
                    send_item(hse_pkg::FUNC_QUERY, pick_query());
                    k++;
                end else if (r < 28) begin
                    send_item(hse_pkg::FUNC_UNUSED, ID_BITS'($urandom_range(ID_MAX)));
                    k++;
                end else if (r < 31) begin
                    send_item(hse_pkg::FUNC_RESTART, ID_BITS'($urandom_range(ID_MAX)));
                    k++;
                end
                send_item(hse_pkg::FUNC_EMIT, ID_BITS'($urandom_range(ID_MAX)));
                k++;
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        quiet     = 1'b0;
        phase     = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, walk before any restart
        send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_QUERY, '0);
        send_item(hse_pkg::FUNC_QUERY, ID_BITS'(ID_MAX));
        send_item(hse_pkg::FUNC_UNUSED, ID_BITS'(ID_MAX));
        send_item(hse_pkg::FUNC_RESTART, '0);
        send_item(hse_pkg::FUNC_EMIT, '0);

        // zero and oversized sizes, a wildcard other than -1
        configure(3, 0, 127, -1, -1, -64);
        send_item(hse_pkg::FUNC_RESTART, '0);
        repeat (4) send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_QUERY, ID_BITS'(191));
        send_item(hse_pkg::FUNC_QUERY, ID_BITS'(192));

        // full cube, single fixed point at the far corner
        configure(64, 64, 64, 63, 63, 63);
        send_item(hse_pkg::FUNC_RESTART, '0);
        send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_QUERY, ID_BITS'(ID_MAX));
        send_item(hse_pkg::FUNC_QUERY, '0);

        // fixed coordinate past its size: empty slice
        configure(4, 2, 2, -1, 2, -1);
        send_item(hse_pkg::FUNC_RESTART, '0);
        send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_QUERY, ID_BITS'(5));

        // size shrinks in the middle of a walk
        configure(4, 4, 1, -1, -1, -1);
        send_item(hse_pkg::FUNC_RESTART, '0);
        repeat (3) send_item(hse_pkg::FUNC_EMIT, '0);
        configure(2, 4, 1, -1, -1, -1);
        send_item(hse_pkg::FUNC_EMIT, '0);
        send_item(hse_pkg::FUNC_EMIT, '0);

        for (ph = 1; ph <= NUM_PHASES; ph++) begin
            random_config();
            quiet = (ph == QUIET_PHASE);
            phase = ph;
            random_phase(PHASE_ITEMS);
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited != 0);
        repeat (100) @(posedge aclk);

        $display("covered %0d emitted ids, %0d walk ends, %0d emits after the end,",
                 n_ids, n_lasts, n_exhausted);
        $display("%0d membership queries with %0d hits, over %0d slice settings",
                 n_queries, n_members, NUM_PHASES + 6);
        if (err_count == 0 && awaited == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
